### rtl/fqmd_pkg.sv
// Shared constants and the stage payload type of the Q16.16 multiply/divide unit.
package fqmd_pkg;

    localparam int OPND_W    = 32;                  // operand and result width
    localparam int FRAC_W    = 16;                  // Q16.16 fraction bits
    localparam int PROD_W    = 2 * OPND_W;          // full product width
    localparam int NQ_W      = OPND_W + FRAC_W;     // scaled dividend / quotient width
    localparam int DIV_STEPS = NQ_W;                // one quotient bit per stage

    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_DIV = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIVZERO = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic              dz;      // divisor is zero
        logic              neg;     // quotient sign
        logic [OPND_W-1:0] mres;    // finished multiply result
        logic [OPND_W-1:0] rem;     // partial remainder
        logic [NQ_W-1:0]   nq;      // dividend bits left, quotient bits shifted in
        logic [OPND_W-1:0] dvs;     // divisor magnitude
    } t_stage;

endpackage

### rtl/fqmd_in_if.sv
// Input channel: operation selector and two Q16.16 operands.
interface fqmd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    cmd;
    logic signed [fqmd_pkg::OPND_W-1:0]      operand_a;
    logic signed [fqmd_pkg::OPND_W-1:0]      operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input cmd, input operand_a, input operand_b,
                    output ready);
endinterface

### rtl/fqmd_out_if.sv
// Output channel: Q16.16 result and status.
interface fqmd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fqmd_pkg::OPND_W-1:0]      result_value;
    logic                                    status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

### rtl/fqmd_front.sv
// Input register, then multiplier and operand magnitude stage.
module fqmd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fqmd_in_if.sink            i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output fqmd_pkg::t_stage   o_data
);
    localparam int W = fqmd_pkg::OPND_W;
    localparam int P = fqmd_pkg::PROD_W;

    logic                r_in_valid;
    logic                r_cmd;
    logic signed [W-1:0] r_a;
    logic signed [W-1:0] r_b;

    logic                r_out_valid;
    fqmd_pkg::t_stage    r_out;

    logic                                  w_out_ready;
    logic                                  w_in_ready;
    logic signed [fqmd_pkg::PROD_W-1:0]    w_prod;
    logic        [W-1:0]                   w_abs_a;
    logic        [W-1:0]                   w_abs_b;
    fqmd_pkg::t_stage                      n_out;

    assign w_out_ready = !r_out_valid || i_ready;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign i_in.ready  = w_in_ready;

    always_comb begin
        w_prod  = P'(r_a) * P'(r_b);
        // magnitude of the most negative value is 2^31, which fits unsigned
        w_abs_a = r_a[W-1] ? (~r_a + W'(1)) : r_a;
        w_abs_b = r_b[W-1] ? (~r_b + W'(1)) : r_b;
        n_out.cmd  = r_cmd;
        n_out.dz   = (r_b == '0);
        n_out.neg  = r_a[W-1] ^ r_b[W-1];
        n_out.mres = w_prod[fqmd_pkg::FRAC_W +: W];
        n_out.rem  = '0;
        n_out.nq   = {w_abs_a, {fqmd_pkg::FRAC_W{1'b0}}};
        n_out.dvs  = w_abs_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready)  r_in_valid  <= i_in.valid;
            if (w_out_ready) r_out_valid <= r_in_valid;
        end
        if (i_in.valid && w_in_ready) begin
            r_cmd <= i_in.cmd;
            r_a   <= i_in.operand_a;
            r_b   <= i_in.operand_b;
        end
        if (r_in_valid && w_out_ready) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

### rtl/fqmd_div_stage.sv
// One restoring division step: develops one quotient bit per stage.
module fqmd_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqmd_pkg::t_stage   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output fqmd_pkg::t_stage   o_data
);
    localparam int W  = fqmd_pkg::OPND_W;
    localparam int NQ = fqmd_pkg::NQ_W;

    logic             r_valid;
    fqmd_pkg::t_stage r_data;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;
    fqmd_pkg::t_stage n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_trial = {i_data.rem, i_data.nq[NQ-1]};
        w_diff  = w_trial - {1'b0, i_data.dvs};
        w_ge    = (w_trial >= {1'b0, i_data.dvs});
        n_data      = i_data;
        // remainder stays below the divisor, so W bits suffice
        n_data.rem  = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        n_data.nq   = {i_data.nq[NQ-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### rtl/fqmd_back.sv
// Sign fix-up, result select and output register.
module fqmd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqmd_pkg::t_stage   i_data,
    fqmd_out_if.source         o_out
);
    localparam int W = fqmd_pkg::OPND_W;

    logic         r_valid;
    logic [W-1:0] r_result;
    logic         r_status;

    logic [W-1:0] w_quot;
    logic [W-1:0] n_result;
    logic         n_status;

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        w_quot   = i_data.nq[W-1:0];
        n_result = i_data.mres;
        n_status = fqmd_pkg::STATUS_OK;
        if (i_data.cmd == fqmd_pkg::CMD_DIV) begin
            if (i_data.dz) begin
                n_result = '0;
                n_status = fqmd_pkg::STATUS_DIVZERO;
            end else begin
                n_result = i_data.neg ? (~w_quot + W'(1)) : w_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.result_value = r_result;
    assign o_out.status       = r_status;
endmodule

### rtl/fixed_point_q16_mul_div_top.sv
// Top level of the pipelined signed Q16.16 multiply/divide unit.
// Usage:
//   i_in  : valid/ready channel carrying cmd (0 multiply, 1 divide),
//           operand_a and operand_b, both signed Q16.16.
//   o_out : valid/ready channel carrying result_value (low 32 bits of the
//           Q16.16 result) and status (1 on divide by zero, result then 0).
//   Every item gives exactly one result, in order.
// An item passes the input register, the multiplier/magnitude stage, 48
// restoring division stages (one quotient bit each, set by the 48-bit
// scaled dividend) and the output register before o_out.valid rises.
// Multiplies ride the same pipe, so ordering is kept. Throughput is one
// item per cycle while o_out.ready stays high. Each stage holds while its
// successor is full and stalled, so a stalled receiver backs the pipe up
// one stage at a time; bubbles still fill and the input keeps accepting
// until every stage is occupied. Nothing is dropped or repeated.
// Synchronous active-low reset empties all stages; o_out.valid goes low and
// i_in.ready is high on the first cycle after reset.
module fixed_point_q16_mul_div_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqmd_in_if.sink     i_in,
    fqmd_out_if.source  o_out
);
    localparam int N = fqmd_pkg::DIV_STEPS;

    logic             w_valid [0:N];
    logic             w_ready [0:N];
    fqmd_pkg::t_stage w_data  [0:N];

    fqmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_div
        fqmd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    fqmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_data  (w_data[N]),
        .o_out   (o_out)
    );
endmodule

### rtl/fqmd_checker.sv
// Port-level checks for the Q16.16 multiply/divide unit, bound to the top level.
module fqmd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [fqmd_pkg::OPND_W-1:0]  i_out_result,
    input logic                         i_out_status
);
    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty output register means the whole pipe can move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output is empty");

    // divide by zero returns zero
    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == fqmd_pkg::STATUS_DIVZERO) |-> i_out_result == '0)
        else $error("nonzero result on divide by zero");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_result) && $stable(i_out_status)))
        else $error("stalled result changed");
endmodule

bind fixed_point_q16_mul_div_top fqmd_checker u_fqmd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result_value),
    .i_out_status (o_out.status)
);

### tb/tb_fixed_point_q16_mul_div_top.sv
// Self-checking testbench for the Q16.16 multiply/divide unit: directed and random items.
module tb_fixed_point_q16_mul_div_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [fqmd_pkg::OPND_W-1:0] t_q16;
    typedef logic signed [fqmd_pkg::PROD_W-1:0] t_q16_wide;

    typedef struct {
        logic cmd;
        t_q16 a;
        t_q16 b;
        bit   drain_first;  // hold off until every earlier result is back
    } t_op_item;

    typedef struct {
        t_q16 value;
        logic status;
    } t_q16_result;

    localparam t_q16 Q16_MAX = 32'sh7fff_ffff;
    localparam t_q16 Q16_MIN = 32'sh8000_0000;
    localparam t_q16 Q16_ONE = 32'sh0001_0000;

    localparam int QUIET_LO = 700;
    localparam int QUIET_HI = 1100;
    localparam int N_RANDOM = 1800;

    logic i_clk;
    logic rst_n;

    fqmd_in_if  in_ch ();
    fqmd_out_if out_ch ();

    fixed_point_q16_mul_div_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_op_item    op_pending_q[$];
    t_q16_result result_due_q[$];

    int n_sent;
    int n_mul;
    int n_div;
    int n_divzero;
    int n_checked;
    int n_err;

    t_op_item    next_op;
    t_q16_result got_due;

    // Multiply keeps product bits [47:16]; divide scales by 2^16 and truncates toward zero.
    function automatic t_q16_result q16_mul_div(input logic cmd, input t_q16 a, input t_q16 b);
        t_q16_wide   wa;
        t_q16_wide   wb;
        t_q16_wide   wide;
        t_q16_result r;
        wa       = t_q16_wide'(a);
        wb       = t_q16_wide'(b);
        r.value  = '0;
        r.status = fqmd_pkg::STATUS_OK;
        if (cmd == fqmd_pkg::CMD_MUL) begin
            wide    = wa * wb;
            r.value = wide[fqmd_pkg::FRAC_W +: fqmd_pkg::OPND_W];
        end else if (b == '0) begin
            r.status = fqmd_pkg::STATUS_DIVZERO;
        end else begin
            wide    = (wa <<< fqmd_pkg::FRAC_W) / wb;
            r.value = wide[fqmd_pkg::OPND_W-1:0];
        end
        return r;
    endfunction

    function automatic t_q16 rand_q16();
        t_q16 v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom();
            4, 5: begin
                v = $urandom_range(32'h0010_0000);
                if ($urandom_range(1)) v = -v;
            end
            6: begin
                case ($urandom_range(6))
                    0: v = Q16_MAX;
                    1: v = Q16_MIN;
                    2: v = '0;
                    3: v = 32'sd1;
                    4: v = -32'sd1;
                    5: v = Q16_ONE;
                    default: v = -Q16_ONE;
                endcase
            end
            7: begin
                v = 32'sd1 <<< $urandom_range(fqmd_pkg::OPND_W-1);
                if ($urandom_range(1)) v = -v;
            end
            default: v = $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
        endcase
        return v;
    endfunction

    task automatic add_op(input logic cmd, input t_q16 a, input t_q16 b, input bit drain);
        t_op_item it;
        it.cmd         = cmd;
        it.a           = a;
        it.b           = b;
        it.drain_first = drain;
        op_pending_q.push_back(it);
    endtask

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sender
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                result_due_q.push_back(q16_mul_div(in_ch.cmd, in_ch.operand_a, in_ch.operand_b));
                n_sent++;
                if (in_ch.cmd == fqmd_pkg::CMD_MUL) begin
                    n_mul++;
                end else begin
                    n_div++;
                    if (in_ch.operand_b == '0) n_divzero++;
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (op_pending_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (op_pending_q[0].drain_first && result_due_q.size() != 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!(n_sent >= QUIET_LO && n_sent < QUIET_HI)
                             && $urandom_range(99) < 8) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    next_op = op_pending_q.pop_front();
                    in_ch.cmd       <= next_op.cmd;
                    in_ch.operand_a <= next_op.a;
                    in_ch.operand_b <= next_op.b;
                    in_ch.valid     <= 1'b1;
                end
            end
        end
    end

    // Receiver and checker
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (result_due_q.size() == 0) begin
                    $display("%0t: result with nothing due: value %h status %b",
                             $realtime, out_ch.result_value, out_ch.status);
                    n_err++;
                end else begin
                    got_due = result_due_q.pop_front();
                    n_checked++;
                    if (out_ch.result_value !== got_due.value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $realtime, got_due.value, out_ch.result_value);
                        n_err++;
                    end
                    if (out_ch.status !== got_due.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $realtime, got_due.status, out_ch.status);
                        n_err++;
                    end
                end
            end
            out_ch.ready <= (n_checked >= QUIET_LO && n_checked < QUIET_HI)
                            || ($urandom_range(99) >= 8);
        end
    end

    initial begin
        logic cmd;
        t_q16 a;
        t_q16 b;
        i_clk           = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = fqmd_pkg::CMD_MUL;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;
        n_sent    = 0;
        n_mul     = 0;
        n_div     = 0;
        n_divzero = 0;
        n_checked = 0;
        n_err     = 0;

        // directed: field extremes, both operations, divide by zero, wrap on overflow
        add_op(fqmd_pkg::CMD_MUL, Q16_MAX, Q16_MAX, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, Q16_MIN, Q16_MIN, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, Q16_MIN, Q16_MAX, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, '0, Q16_MIN, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, Q16_ONE, -32'sd12345, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, -32'sd1, 32'sd1, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, 32'sh0001_8000, 32'sh0002_4000, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, 32'sh0100_0000, 32'sh0100_0000, 1'b0);
        add_op(fqmd_pkg::CMD_MUL, -32'sd3, 32'sd21845, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MAX, '0, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MIN, '0, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, '0, '0, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MIN, -32'sd1, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MAX, 32'sd1, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MIN, Q16_MIN, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_MAX, Q16_MIN, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_ONE, Q16_ONE, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, -32'sd7, 32'sd131072, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, 32'sd7, -32'sd3, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, '0, Q16_MAX, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, Q16_ONE, 32'sh0003_0000, 1'b0);
        add_op(fqmd_pkg::CMD_DIV, -Q16_ONE, Q16_MAX, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            cmd = 1'($urandom_range(1));
            a   = rand_q16();
            b   = (cmd == fqmd_pkg::CMD_DIV && $urandom_range(19) == 0) ? '0 : rand_q16();
            add_op(cmd, a, b, i == 0 || i == 1200);
        end

        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        while (op_pending_q.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (result_due_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Sent %0d multiplies and %0d divides (%0d by zero), with random stalls on both",
                 n_mul, n_div, n_divzero);
        $display("sides; %0d results compared, %0d mismatches.", n_checked, n_err);
        if (n_err == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still due", result_due_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
